// ===== hw/rtl/zrt_pkg.sv =====
// Package for the zone record tokenizer: character codes, close codes and
// the result record shared by the scanner, the top level and the checker.
// Depends on nothing.
`default_nettype none

package zrt_pkg;

  // Character codes that steer the scanner.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChNl    = 8'h0A;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;

  // Token close codes.
  localparam logic [1:0] CloseNone   = 2'd0;
  localparam logic [1:0] CloseBefore = 2'd1;
  localparam logic [1:0] CloseAfter  = 2'd2;

  // One result per text byte.
  typedef struct packed {
    logic        in_token;
    logic        token_begins;
    logic [1:0]  token_closes;
    logic [9:0]  token_number;
    logic        record_done;
    logic        record_skipped;
    logic [15:0] record_length;
    logic        owner_omitted;
    logic        token_overflow;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/zrt_if.sv =====
// Valid/ready channel interfaces for the tokenizer's byte input and
// per-byte result output. Depends on nothing.
`default_nettype none

interface zrt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_input;

  modport source (output valid, text_byte, end_of_input, input ready);
  modport sink   (input valid, text_byte, end_of_input, output ready);
endinterface

interface zrt_out_if;
  logic        valid;
  logic        ready;
  logic        in_token;
  logic        token_begins;
  logic [1:0]  token_closes;
  logic [9:0]  token_number;
  logic        record_done;
  logic        record_skipped;
  logic [15:0] record_length;
  logic        owner_omitted;
  logic        token_overflow;

  modport source (output valid, in_token, token_begins, token_closes, token_number,
                  record_done, record_skipped, record_length, owner_omitted,
                  token_overflow, input ready);
  modport sink   (input valid, in_token, token_begins, token_closes, token_number,
                  record_done, record_skipped, record_length, owner_omitted,
                  token_overflow, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/zone_record_tokenizer_top.sv =====
// Path: an accepted byte is held in the input register; its result is computed
// by the scanner and registered in the output register as stage one moves on.
// Throughput: one byte per cycle; the input register refills while a result
// waits in the output register, limited only by the output ready.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// scanner to outside parentheses, between tokens, with an empty record.
// Top level of the zone record tokenizer. Depends on zrt_pkg, zrt_if, zrt_scan.
`default_nettype none

module zone_record_tokenizer_top #(
  parameter int MAX_TOKENS  = 1024,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  zrt_in_if.sink      in_i,
  zrt_out_if.source   out_o
);
  import zrt_pkg::*;

  logic       s1_valid_q;
  logic [7:0] byte_q;
  logic       eoi_q;
  logic       out_valid_q;
  res_t       res_q, res;
  logic       s1_adv, step, in_acc;

  // Stage one moves on when the output register is empty or being drained.
  assign s1_adv     = !out_valid_q || out_o.ready;
  assign step       = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  zrt_scan #(
    .MAX_TOKENS (MAX_TOKENS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_zrt_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .text_byte_i   (byte_q),
    .end_of_input_i(eoi_q),
    .res_o         (res)
  );

  // Valid bits of the input and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (step) begin
        s1_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= in_i.text_byte;
      eoi_q  <= in_i.end_of_input;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.in_token       = res_q.in_token;
  assign out_o.token_begins   = res_q.token_begins;
  assign out_o.token_closes   = res_q.token_closes;
  assign out_o.token_number   = res_q.token_number;
  assign out_o.record_done    = res_q.record_done;
  assign out_o.record_skipped = res_q.record_skipped;
  assign out_o.record_length  = res_q.record_length;
  assign out_o.owner_omitted  = res_q.owner_omitted;
  assign out_o.token_overflow = res_q.token_overflow;

endmodule

`default_nettype wire

// ===== hw/rtl/zrt_scan.sv =====
// Scanner state machine: holds the record state and computes the result
// for one text byte each time it steps. Depends on zrt_pkg.
`default_nettype none

module zrt_scan #(
  parameter int MAX_TOKENS  = 1024,
  parameter int LENGTH_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        end_of_input_i,
  output zrt_pkg::res_t    res_o
);
  import zrt_pkg::*;

  localparam int CntW = $clog2(MAX_TOKENS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_TOKENS);
  localparam logic [CntW-1:0] LastNum = CntW'(MAX_TOKENS - 1);

  typedef enum logic [2:0] {
    OutGap, OutTok, OutCmt, InGap, InTok, InCmt
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [CntW-1:0]        cnt_q, cnt_d, cnt_n;
  logic [LENGTH_BITS-1:0] bytes_q, bytes_d, bytes_n;
  logic                   owner_q, owner_d, owner_n;
  logic                   ovf_q, ovf_d, ovf_n;

  logic            blank, nl, nl_end, open_tok, intok, rec_end;
  logic [1:0]      closes;
  logic [CntW-1:0] num, cur_num;
  logic [31:0]     num_ext, len_ext;

  assign blank   = (text_byte_i == ChSpace) || (text_byte_i == ChTab) ||
                   (text_byte_i == ChFf);
  assign nl      = (text_byte_i == ChNl);
  assign cur_num = (cnt_q == '0) ? '0 : cnt_q - 1'b1;

  // Mode transitions and token marks for this byte.
  always_comb begin
    mode_d   = mode_q;
    nl_end   = 1'b0;
    open_tok = 1'b0;
    intok    = 1'b0;
    closes   = CloseNone;
    case (mode_q)
      OutGap: begin
        if (nl) begin
          nl_end = 1'b1;
        end else if (blank) begin
          mode_d = OutGap;
        end else if (text_byte_i == ChSemi) begin
          mode_d = OutCmt;
        end else if (text_byte_i == ChLpar) begin
          mode_d = InGap;
        end else begin
          open_tok = 1'b1;
          mode_d   = OutTok;
        end
      end
      OutTok: begin
        if (nl || blank) begin
          closes = CloseBefore;
          mode_d = OutGap;
          nl_end = nl;
        end else begin
          intok = 1'b1;
        end
      end
      OutCmt: begin
        if (nl) begin
          nl_end = 1'b1;
          mode_d = OutGap;
        end
      end
      InGap: begin
        if (nl || blank) begin
          mode_d = InGap;
        end else if (text_byte_i == ChSemi) begin
          mode_d = InCmt;
        end else if (text_byte_i == ChRpar) begin
          mode_d = OutGap;
        end else begin
          open_tok = 1'b1;
          mode_d   = InTok;
        end
      end
      InTok: begin
        if (nl || blank) begin
          closes = CloseBefore;
          mode_d = InGap;
        end else if (text_byte_i == ChRpar) begin
          closes = CloseBefore;
          mode_d = OutGap;
        end else begin
          intok = 1'b1;
        end
      end
      InCmt: begin
        if (nl) begin
          mode_d = InGap;
        end
      end
      default: begin
        mode_d = OutGap;
      end
    endcase
    if (open_tok) begin
      intok = 1'b1;
    end
    if (end_of_input_i && !nl_end && intok) begin
      closes = CloseAfter;
    end
    if (nl_end || end_of_input_i) begin
      mode_d = OutGap;
    end
  end

  // Token counting, saturating length and record flags.
  always_comb begin
    cnt_n   = cnt_q;
    owner_n = owner_q;
    ovf_n   = ovf_q;
    num     = cur_num;
    if (open_tok) begin
      if (cnt_q == '0) begin
        owner_n = (bytes_q != '0);
      end
      if (cnt_q >= MaxCnt) begin
        ovf_n = 1'b1;
        num   = LastNum;
      end else begin
        num   = cnt_q;
        cnt_n = cnt_q + 1'b1;
      end
    end
    bytes_n = bytes_q;
    if (!nl_end && (bytes_q != '1)) begin
      bytes_n = bytes_q + 1'b1;
    end
  end

  assign rec_end = nl_end || end_of_input_i;
  assign cnt_d   = rec_end ? '0 : cnt_n;
  assign bytes_d = rec_end ? '0 : bytes_n;
  assign owner_d = rec_end ? 1'b0 : owner_n;
  assign ovf_d   = rec_end ? 1'b0 : ovf_n;

  assign num_ext = 32'(num);
  assign len_ext = 32'(bytes_n);

  // Result fields; record fields are zero unless a record is reported.
  always_comb begin
    res_o                = '0;
    res_o.in_token       = intok;
    res_o.token_begins   = open_tok;
    res_o.token_closes   = closes;
    res_o.token_number   = (intok || (closes != CloseNone)) ? num_ext[9:0] : 10'd0;
    res_o.record_done    = rec_end && (cnt_n != '0);
    res_o.record_skipped = rec_end && (cnt_n == '0);
    if (rec_end && (cnt_n != '0)) begin
      res_o.record_length  = (len_ext > 32'd65535) ? 16'hFFFF : len_ext[15:0];
      res_o.owner_omitted  = owner_n;
      res_o.token_overflow = ovf_n;
    end
  end

  // Scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= OutGap;
      cnt_q   <= '0;
      bytes_q <= '0;
      owner_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      cnt_q   <= cnt_d;
      bytes_q <= bytes_d;
      owner_q <= owner_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/zrt_checker.sv =====
// Port-level checks for the zone record tokenizer and the bind that
// attaches them to the top level. Depends on zrt_pkg.
`default_nettype none

module zrt_assertions (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        in_token_i,
  input wire logic        token_begins_i,
  input wire logic [1:0]  token_closes_i,
  input wire logic [9:0]  token_number_i,
  input wire logic        record_done_i,
  input wire logic [15:0] record_length_i,
  input wire logic        owner_omitted_i,
  input wire logic        token_overflow_i
);
  import zrt_pkg::*;

  // A stalled result keeps its token number, close code and record length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_number_i) &&
      $stable(record_length_i) && $stable(token_closes_i))
    else $error("stalled result changed");

  // With the output register empty the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input blocked while output empty");

  // Token marks agree with each other.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (!token_begins_i || in_token_i) &&
      (token_closes_i != CloseAfter || in_token_i) &&
      (token_closes_i == CloseNone || token_closes_i == CloseBefore ||
       token_closes_i == CloseAfter))
    else $error("inconsistent token marks");

  // Record fields stay zero unless a record is reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !record_done_i |->
      record_length_i == 16'd0 && !owner_omitted_i && !token_overflow_i)
    else $error("record fields set without a finished record");

endmodule

bind zone_record_tokenizer_top zrt_assertions u_zrt_assertions (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .in_token_i      (out_o.in_token),
  .token_begins_i  (out_o.token_begins),
  .token_closes_i  (out_o.token_closes),
  .token_number_i  (out_o.token_number),
  .record_done_i   (out_o.record_done),
  .record_length_i (out_o.record_length),
  .owner_omitted_i (out_o.owner_omitted),
  .token_overflow_i(out_o.token_overflow)
);

`default_nettype wire

// ===== sim/zrt_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the zone record tokenizer: watches both channels,
// predicts the result of every accepted byte and compares it with the block.
// Depends on zrt_pkg and zrt_if.

module zrt_checker #(
  parameter int MAX_TOKENS  = 1024,
  parameter int LENGTH_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  zrt_in_if    in_i,
  zrt_out_if   out_i,
  output int   mismatch_count_o,
  output int   pending_o
);
  import zrt_pkg::*;

  typedef enum logic [2:0] {
    ModeOutGap,
    ModeOutTok,
    ModeOutCmt,
    ModeInGap,
    ModeInTok,
    ModeInCmt
  } scan_mode_e;

  // Shadow copy of the scanner state.
  scan_mode_e       mode_q;
  int unsigned      tokens_seen;
  longint unsigned  rec_bytes;
  logic             owner_late;
  logic             too_many;

  res_t byte_results_q[$];
  int   mismatches;

  assign mismatch_count_o = mismatches;
  assign pending_o        = byte_results_q.size();

  function automatic logic is_blank(logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChFf;
  endfunction

  // Returns the scanner to an empty record between tokens.
  function automatic void clear_record();
    mode_q      = ModeOutGap;
    tokens_seen = 0;
    rec_bytes   = 0;
    owner_late  = 1'b0;
    too_many    = 1'b0;
  endfunction

  // Counts a new token; past the token limit it only raises the overflow flag.
  function automatic int unsigned begin_token();
    int unsigned idx;
    if (tokens_seen == 0) owner_late = (rec_bytes != 0);
    if (tokens_seen >= MAX_TOKENS) begin
      too_many = 1'b1;
      idx      = MAX_TOKENS - 1;
    end else begin
      idx = tokens_seen;
      tokens_seen++;
    end
    return idx;
  endfunction

  function automatic int unsigned open_index();
    return (tokens_seen == 0) ? 0 : tokens_seen - 1;
  endfunction

  // Advances the shadow scanner by one byte and forms the expected result.
  task automatic scan_text_byte(input logic [7:0] c, input logic last, output res_t r);
    logic            tok;
    logic            starts;
    logic            nl_end;
    logic            done;
    logic            skipped;
    logic [1:0]      closes;
    int unsigned     num;
    longint unsigned len;
    longint unsigned cap;
    tok     = 1'b0;
    starts  = 1'b0;
    nl_end  = 1'b0;
    done    = 1'b0;
    skipped = 1'b0;
    closes  = CloseNone;
    num     = 0;
    len     = 0;
    cap     = (64'd1 << LENGTH_BITS) - 1;
    r       = '0;

    case (mode_q)
      ModeOutGap: begin
        if (c == ChNl) nl_end = 1'b1;
        else if (is_blank(c)) begin
        end else if (c == ChSemi) mode_q = ModeOutCmt;
        else if (c == ChLpar) mode_q = ModeInGap;
        else begin
          num    = begin_token();
          starts = 1'b1;
          tok    = 1'b1;
          mode_q = ModeOutTok;
        end
      end
      ModeOutTok: begin
        if (c == ChNl || is_blank(c)) begin
          closes = CloseBefore;
          num    = open_index();
          mode_q = ModeOutGap;
          nl_end = (c == ChNl);
        end else begin
          tok = 1'b1;
          num = open_index();
        end
      end
      ModeOutCmt: begin
        if (c == ChNl) begin
          nl_end = 1'b1;
          mode_q = ModeOutGap;
        end
      end
      ModeInGap: begin
        if (c == ChNl || is_blank(c)) begin
        end else if (c == ChSemi) mode_q = ModeInCmt;
        else if (c == ChRpar) mode_q = ModeOutGap;
        else begin
          num    = begin_token();
          starts = 1'b1;
          tok    = 1'b1;
          mode_q = ModeInTok;
        end
      end
      ModeInTok: begin
        if (c == ChNl || is_blank(c)) begin
          closes = CloseBefore;
          num    = open_index();
          mode_q = ModeInGap;
        end else if (c == ChRpar) begin
          closes = CloseBefore;
          num    = open_index();
          mode_q = ModeOutGap;
        end else begin
          tok = 1'b1;
          num = open_index();
        end
      end
      ModeInCmt: begin
        if (c == ChNl) mode_q = ModeInGap;
      end
      default: mode_q = ModeOutGap;
    endcase

    // The record length counts every byte but a terminating newline.
    if (!nl_end && rec_bytes < cap) rec_bytes++;
    if (last && !nl_end && tok) closes = CloseAfter;

    // A newline outside parentheses or the end of the file closes the record.
    if (nl_end || last) begin
      if (tokens_seen != 0) begin
        done              = 1'b1;
        len               = rec_bytes;
        r.owner_omitted   = owner_late;
        r.token_overflow  = too_many;
      end else begin
        skipped = 1'b1;
      end
      clear_record();
    end

    if (!tok && closes == CloseNone) num = 0;
    r.in_token       = tok;
    r.token_begins   = starts;
    r.token_closes   = closes;
    r.token_number   = 10'(num);
    r.record_done    = done;
    r.record_skipped = skipped;
    r.record_length  = (len > 65535) ? 16'hFFFF : 16'(len);
  endtask

  // Predict on each accepted byte and compare each accepted result.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    res_t got;
    if (!rst_ni) begin
      clear_record();
      byte_results_q.delete();
      mismatches = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        got.in_token       = out_i.in_token;
        got.token_begins   = out_i.token_begins;
        got.token_closes   = out_i.token_closes;
        got.token_number   = out_i.token_number;
        got.record_done    = out_i.record_done;
        got.record_skipped = out_i.record_skipped;
        got.record_length  = out_i.record_length;
        got.owner_omitted  = out_i.owner_omitted;
        got.token_overflow = out_i.token_overflow;
        if (byte_results_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no byte outstanding", $realtime);
          mismatches++;
        end else begin
          want = byte_results_q.pop_front();
          if (got.in_token !== want.in_token || got.token_begins !== want.token_begins ||
              got.token_closes !== want.token_closes ||
              got.token_number !== want.token_number ||
              got.record_done !== want.record_done ||
              got.record_skipped !== want.record_skipped ||
              got.record_length !== want.record_length ||
              got.owner_omitted !== want.owner_omitted ||
              got.token_overflow !== want.token_overflow) begin
            if (mismatches < 10) begin
              $display("%0t: expected tok=%b beg=%b cls=%0d num=%0d done=%b skip=%b len=%0d own=%b ovf=%b",
                       $realtime, want.in_token, want.token_begins, want.token_closes,
                       want.token_number, want.record_done, want.record_skipped,
                       want.record_length, want.owner_omitted, want.token_overflow);
              $display("%0t: actual   tok=%b beg=%b cls=%0d num=%0d done=%b skip=%b len=%0d own=%b ovf=%b",
                       $realtime, got.in_token, got.token_begins, got.token_closes,
                       got.token_number, got.record_done, got.record_skipped,
                       got.record_length, got.owner_omitted, got.token_overflow);
            end
            mismatches++;
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        scan_text_byte(in_i.text_byte, in_i.end_of_input, want);
        byte_results_q.push_back(want);
      end
    end
  end

endmodule

// ===== sim/zone_record_tokenizer_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the zone record tokenizer: drives zone-file text with
// random gaps and output stalls, and gives the verdict from the checker.
// Depends on zrt_pkg, zrt_if, zrt_checker and the tokenizer RTL.

module zone_record_tokenizer_top_tb;
  import zrt_pkg::*;

  localparam int MAX_TOKENS   = 1024;
  localparam int LENGTH_BITS  = 16;
  localparam int RANDOM_BYTES = 1250;
  localparam int DRAIN_CYCLES = 10;

  logic clk_i;
  logic rst_ni;
  int   mismatch_count;
  int   pending;
  int   bytes_sent;
  bit   in_idle_en;
  bit   out_stall_en;
  bit   end_file;
  logic [7:0] text_q[$];

  zrt_in_if  in_ch ();
  zrt_out_if out_ch ();

  zone_record_tokenizer_top #(
    .MAX_TOKENS (MAX_TOKENS),
    .LENGTH_BITS(LENGTH_BITS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  zrt_checker #(
    .MAX_TOKENS (MAX_TOKENS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_i            (in_ch),
    .out_i           (out_ch),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] blank_byte();
    int r;
    r = $urandom_range(0, 2);
    return (r == 0) ? ChSpace : (r == 1) ? ChTab : ChFf;
  endfunction

  // Any byte that neither separates nor steers the scanner.
  function automatic logic [7:0] token_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == ChSpace || c == ChTab || c == ChFf || c == ChNl ||
           c == ChSemi || c == ChLpar || c == ChRpar);
    return c;
  endfunction

  // Output side: ready runs broken by stalls, with stall-free stretches.
  initial begin : out_ready
    int   run_left;
    logic rdy;
    out_ch.ready = 1'b0;
    out_stall_en = 1'b1;
    rdy          = 1'b1;
    run_left     = 0;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        if ($urandom_range(0, 199) == 0) out_stall_en = !out_stall_en;
        if (rdy && out_stall_en) begin
          run_left = pick_gap();
          rdy      = (run_left == 0);
        end else begin
          rdy = 1'b1;
        end
        if (run_left == 0) run_left = $urandom_range(1, 12);
      end
      out_ch.ready <= rdy;
      run_left--;
    end
  end

  // Presents one byte after an optional gap and holds it until accepted.
  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = in_idle_en ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.text_byte    <= c;
    in_ch.end_of_input <= last;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic flush_text();
    for (int i = 0; i < text_q.size(); i++)
      send_byte(text_q[i], end_file && i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Separator: blanks, and inside a group also newlines and comments.
  task automatic push_gap(input bit grouped);
    int n;
    n = $urandom_range(1, 3);
    repeat (n) text_q.push_back(blank_byte());
    if (grouped && $urandom_range(0, 2) == 0) text_q.push_back(ChNl);
    if (grouped && $urandom_range(0, 4) == 0) begin
      text_q.push_back(ChSemi);
      repeat ($urandom_range(0, 6)) text_q.push_back(token_byte());
      text_q.push_back(ChNl);
    end
  endtask

  // A token, sometimes with steering characters where they are plain bytes.
  task automatic push_token(input bit grouped);
    int n;
    int r;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
    if (grouped && $urandom_range(0, 5) == 0) text_q.push_back(ChLpar);
    else text_q.push_back(token_byte());
    for (int i = 1; i < n; i++) begin
      r = $urandom_range(0, 15);
      if (r == 0) text_q.push_back(ChSemi);
      else if (r == 1) text_q.push_back(ChLpar);
      else if (r == 2 && !grouped) text_q.push_back(ChRpar);
      else text_q.push_back(token_byte());
    end
  endtask

  // A well-formed record: optional owner, tokens, perhaps a group and a comment.
  task automatic build_record();
    int ntok;
    int grp_at;
    int r;
    bit in_grp;
    in_grp = 1'b0;
    ntok   = $urandom_range(1, 7);
    grp_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, ntok - 1) : -1;
    if ($urandom_range(0, 3) == 0) push_gap(1'b0);
    for (int i = 0; i < ntok; i++) begin
      if (i == grp_at) begin
        text_q.push_back(ChLpar);
        in_grp = 1'b1;
        if ($urandom_range(0, 1) == 1) push_gap(1'b1);
      end
      push_token(in_grp);
      if (in_grp && (i == ntok - 1 || $urandom_range(0, 2) == 0)) begin
        if ($urandom_range(0, 1) == 1) push_gap(1'b1);
        text_q.push_back(ChRpar);
        in_grp = 1'b0;
      end
      if (i < ntok - 1) push_gap(in_grp);
    end
    if ($urandom_range(0, 3) == 0) begin
      push_gap(1'b0);
      text_q.push_back(ChSemi);
      repeat ($urandom_range(0, 8)) text_q.push_back(token_byte());
    end
    // Now and then the file ends here, with or without the newline.
    r        = $urandom_range(0, 39);
    end_file = (r < 2);
    if (r != 0) text_q.push_back(ChNl);
  endtask

  // Noise: arbitrary bytes, or a jumble of the steering characters.
  task automatic build_noise();
    int n;
    int r;
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 8);
      case (r)
        0: text_q.push_back(ChNl);
        1: text_q.push_back(ChSemi);
        2: text_q.push_back(ChLpar);
        3: text_q.push_back(ChRpar);
        4: text_q.push_back(blank_byte());
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    end_file = ($urandom_range(0, 24) == 0);
  endtask

  initial begin : stimulus
    logic [7:0] dir_bytes[25];
    int stop_at;
    dir_bytes = '{8'h00, 8'hFF, ChSemi, ChLpar, ChRpar, ChTab, ChRpar, ChSpace,
                  ChLpar, 8'h61, ChNl, ChLpar, 8'h78, ChRpar, ChSemi, 8'h63, ChNl,
                  ChSpace, 8'h78, ChNl, ChSemi, ChNl, 8'h79, ChFf, ChNl};
    in_ch.valid        = 1'b0;
    in_ch.text_byte    = 8'h00;
    in_ch.end_of_input = 1'b0;
    rst_ni             = 1'b0;
    in_idle_en         = 1'b1;
    end_file           = 1'b0;
    bytes_sent         = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed text: extreme bytes, steering characters inside tokens, a
    // stray close, nested open, comment, omitted owner, and file ends on a
    // token, on a blank and on a newline.
    for (int i = 0; i < 25; i++) send_byte(dir_bytes[i], i >= 22);

    // Random records with some noise.
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 14) == 0) in_idle_en = !in_idle_en;
      end_file = 1'b0;
      if ($urandom_range(0, 99) < 12) build_noise();
      else build_record();
      flush_text();
    end

    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/zrt_pkg.sv
hw/rtl/zrt_if.sv
hw/rtl/zrt_scan.sv
hw/rtl/zone_record_tokenizer_top.sv
hw/rtl/zrt_checker.sv
sim/zrt_checker.sv
sim/zone_record_tokenizer_top_tb.sv
